FILE: sv/swm_pkg.sv
// Shared constants, types and helpers for the sliding window median filter.
// Depends on nothing; every other file of the block refers to it by scoped names.
package swm_pkg;

    // Built window capacity and derived widths.
    localparam int WINDOW_MAX = 64;
    localparam int AW         = $clog2(WINDOW_MAX);
    localparam int CW         = $clog2(WINDOW_MAX + 1);
    localparam int DW         = 32;
    localparam int OW         = DW + 1;
    localparam int WSW        = 7;

    localparam logic [WSW-1:0] WS_RESET = WSW'(3);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic begin_fill;
        logic rd_old;
        logic got_old;
        logic rem_rd;
        logic rem_chk;
        logic ins_rd;
        logic ins_chk;
        logic med_rd0;
        logic med_rd1;
        logic med_acc;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic rem_last;
        logic idx_zero;
        logic ins_gt;
    } t_sts;

    // Effective window length: zero acts as one, large values saturate.
    function automatic logic [CW-1:0] eff_window(input logic [WSW-1:0] ws);
        logic [CW-1:0] k;
        if (ws == '0) begin
            k = CW'(1);
        end else if (int'(ws) > WINDOW_MAX) begin
            k = CW'(WINDOW_MAX);
        end else begin
            k = CW'(ws);
        end
        return k;
    endfunction

endpackage

FILE: sv/swm_channels.sv
// Valid/ready channel interfaces of the sliding window median filter.
// Depends on swm_pkg for the payload widths.
interface swm_smp_if;
    logic                            valid;
    logic                            ready;
    logic signed [swm_pkg::DW-1:0]   sample;
    logic                            restart;
    modport source (output valid, sample, restart, input ready);
    modport sink   (input valid, sample, restart, output ready);
endinterface

interface swm_med_if;
    logic                            valid;
    logic                            ready;
    logic signed [swm_pkg::OW-1:0]   median_doubled;
    modport source (output valid, median_doubled, input ready);
    modport sink   (input valid, median_doubled, output ready);
endinterface

interface swm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [swm_pkg::WSW-1:0]         window_size;
    modport source (output valid, window_size, input ready);
    modport sink   (input valid, window_size, output ready);
endinterface

FILE: sv/swm_datapath.sv
// Datapath of the median filter: arrival ring, sorted store, counters and median adder.
// Depends on swm_pkg; driven by commands from swm_ctrl.
module swm_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swm_pkg::t_cmd                 i_cmd,
    output swm_pkg::t_sts                 o_sts,
    input  logic signed [swm_pkg::DW-1:0] i_sample,
    input  logic                          i_restart,
    input  logic                          i_cfg_we,
    input  logic [swm_pkg::WSW-1:0]       i_cfg_ws,
    output logic signed [swm_pkg::OW-1:0] o_median
);

    logic signed [swm_pkg::DW-1:0] r_arr_mem [swm_pkg::WINDOW_MAX];
    logic signed [swm_pkg::DW-1:0] r_sort_mem [swm_pkg::WINDOW_MAX];
    logic signed [swm_pkg::DW-1:0] r_arr_q;
    logic signed [swm_pkg::DW-1:0] r_sort_q;

    logic [swm_pkg::CW-1:0] r_k, n_k;
    logic [swm_pkg::CW-1:0] r_fill, n_fill;
    logic [swm_pkg::AW-1:0] r_oldest, n_oldest;
    logic [swm_pkg::CW-1:0] r_idx, n_idx;
    logic                   r_found, n_found;
    logic signed [swm_pkg::DW-1:0] r_x, n_x;
    logic signed [swm_pkg::DW-1:0] r_old, n_old;
    logic signed [swm_pkg::OW-1:0] r_acc, n_acc;
    logic signed [swm_pkg::OW-1:0] r_med, n_med;

    logic                   arr_we;
    logic [swm_pkg::AW-1:0] arr_waddr;
    logic                   sort_we;
    logic [swm_pkg::AW-1:0] sort_waddr;
    logic signed [swm_pkg::DW-1:0] sort_wdata;
    logic [swm_pkg::AW-1:0] sort_raddr;
    logic [swm_pkg::CW-1:0] idx_dec;
    logic [swm_pkg::CW-1:0] k_last;
    logic [swm_pkg::CW-1:0] half;
    logic [swm_pkg::CW-1:0] half_lo;
    logic [swm_pkg::CW-1:0] oldest_inc;
    logic signed [swm_pkg::OW-1:0] q_ext;

    assign idx_dec    = r_idx - swm_pkg::CW'(1);
    assign k_last     = r_k - swm_pkg::CW'(1);
    assign half       = r_k >> 1;
    assign half_lo    = r_k[0] ? half : (half - swm_pkg::CW'(1));
    assign oldest_inc = swm_pkg::CW'(r_oldest) + swm_pkg::CW'(1);
    assign q_ext      = {r_sort_q[swm_pkg::DW-1], r_sort_q};

    // Status back to the controller.
    assign o_sts.full     = (r_fill == r_k);
    assign o_sts.rem_last = (r_idx == k_last);
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.ins_gt   = (r_sort_q > r_x);
    assign o_median       = r_med;

    // Arrival ring write: a new sample goes to the fill slot or over the oldest one.
    assign arr_we    = i_cmd.begin_fill | i_cmd.got_old;
    assign arr_waddr = i_cmd.begin_fill ? r_fill[swm_pkg::AW-1:0] : r_oldest;

    // Sorted store read address.
    always_comb begin
        priority if (i_cmd.med_rd0) begin
            sort_raddr = half[swm_pkg::AW-1:0];
        end else if (i_cmd.med_rd1) begin
            sort_raddr = half_lo[swm_pkg::AW-1:0];
        end else if (i_cmd.ins_rd) begin
            sort_raddr = idx_dec[swm_pkg::AW-1:0];
        end else if (i_cmd.rem_rd) begin
            sort_raddr = r_idx[swm_pkg::AW-1:0];
        end else begin
            sort_raddr = r_idx[swm_pkg::AW-1:0];
        end
    end

    // Sorted store write: shift down on removal, shift up or place on insertion.
    always_comb begin
        sort_we    = 1'b0;
        sort_waddr = r_idx[swm_pkg::AW-1:0];
        sort_wdata = r_x;
        priority if (i_cmd.rem_chk && r_found) begin
            sort_we    = 1'b1;
            sort_waddr = idx_dec[swm_pkg::AW-1:0];
            sort_wdata = r_sort_q;
        end else if (i_cmd.ins_rd && (r_idx == '0)) begin
            sort_we    = 1'b1;
        end else if (i_cmd.ins_chk) begin
            sort_we    = 1'b1;
            sort_wdata = o_sts.ins_gt ? r_sort_q : r_x;
        end else begin
            sort_we    = 1'b0;
        end
    end

    // Memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (arr_we) begin
            r_arr_mem[arr_waddr] <= r_x;
        end
        if (i_cmd.rd_old) begin
            r_arr_q <= r_arr_mem[r_oldest];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sort_we) begin
            r_sort_mem[sort_waddr] <= sort_wdata;
        end
        r_sort_q <= r_sort_mem[sort_raddr];
    end

    // Next-state logic of counters and payload registers.
    always_comb begin
        n_k      = r_k;
        n_fill   = r_fill;
        n_oldest = r_oldest;
        n_idx    = r_idx;
        n_found  = r_found;
        n_x      = r_x;
        n_old    = r_old;
        n_acc    = r_acc;
        n_med    = r_med;
        if (i_cfg_we) begin
            n_k      = swm_pkg::eff_window(i_cfg_ws);
            n_fill   = '0;
            n_oldest = '0;
        end
        if (i_cmd.take) begin
            n_x = i_sample;
            if (i_restart) begin
                n_fill   = '0;
                n_oldest = '0;
            end
        end
        if (i_cmd.begin_fill) begin
            n_idx  = r_fill;
            n_fill = r_fill + swm_pkg::CW'(1);
        end
        if (i_cmd.got_old) begin
            n_old    = r_arr_q;
            n_idx    = '0;
            n_found  = 1'b0;
            n_oldest = (oldest_inc == r_k) ? '0 : oldest_inc[swm_pkg::AW-1:0];
        end
        if (i_cmd.rem_chk) begin
            n_found = r_found | (r_sort_q == r_old);
            n_idx   = o_sts.rem_last ? k_last : (r_idx + swm_pkg::CW'(1));
        end
        if (i_cmd.ins_chk && o_sts.ins_gt) begin
            n_idx = idx_dec;
        end
        if (i_cmd.med_rd1) begin
            n_acc = q_ext;
        end
        if (i_cmd.med_acc) begin
            n_acc = r_acc + q_ext;
        end
        if (i_cmd.load_out) begin
            n_med = r_acc;
        end
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= swm_pkg::eff_window(swm_pkg::WS_RESET);
            r_fill   <= '0;
            r_oldest <= '0;
            r_idx    <= '0;
            r_found  <= 1'b0;
        end else begin
            r_k      <= n_k;
            r_fill   <= n_fill;
            r_oldest <= n_oldest;
            r_idx    <= n_idx;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_old <= n_old;
        r_acc <= n_acc;
        r_med <= n_med;
    end

endmodule

FILE: sv/swm_ctrl.sv
// Controller of the median filter: sequences removal, insertion and median read.
// Depends on swm_pkg; drives swm_datapath through command and status structs.
module swm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    input  swm_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output swm_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_OLD,
        S_REM_RD,
        S_REM_CHK,
        S_INS_RD,
        S_INS_CHK,
        S_MED0,
        S_MED1,
        S_MED2,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Command decode and next state.
    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.full) begin
                    o_cmd.rd_old = 1'b1;
                    n_state      = S_OLD;
                end else begin
                    o_cmd.begin_fill = 1'b1;
                    n_state          = S_INS_RD;
                end
            end
            S_OLD: begin
                o_cmd.got_old = 1'b1;
                n_state       = S_REM_RD;
            end
            S_REM_RD: begin
                o_cmd.rem_rd = 1'b1;
                n_state      = S_REM_CHK;
            end
            S_REM_CHK: begin
                o_cmd.rem_chk = 1'b1;
                n_state       = i_sts.rem_last ? S_INS_RD : S_REM_RD;
            end
            S_INS_RD: begin
                o_cmd.ins_rd = 1'b1;
                if (i_sts.idx_zero) begin
                    n_state = i_sts.full ? S_MED0 : S_IDLE;
                end else begin
                    n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                o_cmd.ins_chk = 1'b1;
                if (i_sts.ins_gt) begin
                    n_state = S_INS_RD;
                end else begin
                    n_state = i_sts.full ? S_MED0 : S_IDLE;
                end
            end
            S_MED0: begin
                o_cmd.med_rd0 = 1'b1;
                n_state       = S_MED1;
            end
            S_MED1: begin
                o_cmd.med_rd1 = 1'b1;
                n_state       = S_MED2;
            end
            S_MED2: begin
                o_cmd.med_acc = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: sv/sliding_window_median.sv
// Top level of the sliding window median filter.
// Depends on swm_pkg, the channel interfaces, swm_ctrl and swm_datapath.
// Usage:
//   i_smp carries one signed 32-bit sample and a restart flag per transfer.
//   o_med carries twice the window median (33 bits, signed) per transfer.
//   i_cfg writes window_size; it is always ready and must only be used while
//   the block is idle. A write empties the window. Zero acts as one and values
//   above 64 act as 64. Until the window holds window_size samples, a sample is
//   stored and gives no result; restart empties the window before its sample enters.
// Sequence (k = window length, m = sorted entries the new sample moves past):
//   One sample at a time; the sorted store is scanned one entry at a time, with
//   a read state and a check state per entry. A sample that only fills the
//   window is inserted past m entries before the next transfer; the sample that
//   completes the window adds the median read. On a full window the oldest entry
//   is read from the arrival ring and removed by a scan of all k entries, the new
//   sample is inserted past m entries, the median is read, and o_med.valid is set
//   in the same cycle that the input is ready again.
// Reset and stall: reset empties the window and sets window_size to 3. A result
//   waits in the output register while o_med.ready is low; the next sample is still
//   accepted and is held back only when its own result is ready to load.
module sliding_window_median (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swm_smp_if.sink     i_smp,
    swm_med_if.source   o_med,
    swm_cfg_if.sink     i_cfg
);

    swm_pkg::t_cmd cmd;
    swm_pkg::t_sts sts;

    // Configuration writes complete at once.
    assign i_cfg.ready = 1'b1;

    swm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp.valid),
        .i_out_ready (o_med.ready),
        .i_sts       (sts),
        .o_in_ready  (i_smp.ready),
        .o_out_valid (o_med.valid),
        .o_cmd       (cmd)
    );

    swm_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_sample  (i_smp.sample),
        .i_restart (i_smp.restart),
        .i_cfg_we  (i_cfg.valid),
        .i_cfg_ws  (i_cfg.window_size),
        .o_median  (o_med.median_doubled)
    );

endmodule

FILE: sv/swm_checker.sv
// Port-level checks for the sliding window median filter, bound to the top level.
// Depends on swm_pkg for the result width.
module swm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [swm_pkg::OW-1:0] i_median
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_median))
        else $error("result changed while stalled");

    // Samples are worked on one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // A new result appears only while the input side is busy.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while idle");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_med.valid),
    .i_out_ready (o_med.ready),
    .i_median    (o_med.median_doubled)
);
